FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the decoder project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, disabled while reset is high.
`define U8D_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define U8D_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Types and constants shared by the UTF-8 to UTF-32 decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package u8d_pkg;

   localparam int unsigned CpWidth     = 21;
   localparam int unsigned CountWidth  = 16;
   localparam int unsigned StatusWidth = 3;

   // Result status codes.
   localparam logic [StatusWidth-1:0] ST_POINT   = 3'd0;
   localparam logic [StatusWidth-1:0] ST_DONE    = 3'd1;
   localparam logic [StatusWidth-1:0] ST_NOSPACE = 3'd2;
   localparam logic [StatusWidth-1:0] ST_BADCONT = 3'd3;
   localparam logic [StatusWidth-1:0] ST_BADLEAD = 3'd4;

   // Byte class masks and patterns.
   localparam logic [7:0] ASCII_MASK = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_PAT  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_PAT  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_PAT  = 8'hF0;
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_PAT   = 8'h80;

   localparam logic [CountWidth-1:0] CAPACITY_RESET = 16'hFFFF;

   // Result queue depth; one decoded byte can produce two results.
   localparam int unsigned QueueDepth = 4;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [CpWidth-1:0]     code_point;
      logic [CountWidth-1:0]  emitted_count;
      logic                   run_end;
   } result_type;

   typedef struct packed {
      logic [1:0] count;    // number of results produced: 0, 1 or 2
      result_type first;
      result_type second;
   } push_type;

endpackage

`default_nettype wire

FILE: rtl/u8d_decode.sv
// ----------------------------------------------------------------------------
// u8d_decode
// Per-byte decode step: holds the sequence state and produces up to two
// results for each accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_decode (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_accept,
   input  wire logic [7:0]                      in_byte,
   input  wire logic                            in_last,
   input  wire logic [u8d_pkg::CountWidth-1:0]  capacity,
   output u8d_pkg::push_type                    push
);
   import u8d_pkg::*;

   logic [1:0]            owed_ff, owed_in;
   logic [CpWidth-1:0]    partial_ff, partial_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  discard_ff, discard_in;

   always_comb begin
      logic                   emit;
      logic                   err;
      logic [StatusWidth-1:0] err_status;
      logic [CpWidth-1:0]     emit_cp;
      logic [CpWidth-1:0]     shifted;
      logic [CountWidth-1:0]  cnt_inc;
      logic [CountWidth:0]    cnt_next_slot;
      logic                   lead_ok;

      owed_in       = owed_ff;
      partial_in    = partial_ff;
      count_in      = count_ff;
      discard_in    = discard_ff;
      push          = '0;
      emit          = 1'b0;
      err           = 1'b0;
      err_status    = ST_BADLEAD;
      emit_cp       = '0;
      lead_ok       = 1'b0;
      shifted       = {partial_ff[CpWidth-7:0], in_byte[5:0]};
      cnt_inc       = count_ff + 16'd1;
      cnt_next_slot = {1'b0, cnt_inc} + 17'd1;

      if (in_accept) begin
         if (discard_ff) begin
            if (in_last) begin
               discard_in = 1'b0;
            end
         end else if (owed_ff == 2'd0) begin
            if ((in_byte & ASCII_MASK) == 8'h00) begin
               emit    = 1'b1;
               emit_cp = {13'd0, in_byte};
            end else if ((in_byte & LEAD2_MASK) == LEAD2_PAT) begin
               partial_in = {16'd0, in_byte[4:0]};
               owed_in    = 2'd1;
               lead_ok    = 1'b1;
            end else if ((in_byte & LEAD3_MASK) == LEAD3_PAT) begin
               partial_in = {17'd0, in_byte[3:0]};
               owed_in    = 2'd2;
               lead_ok    = 1'b1;
            end else if ((in_byte & LEAD4_MASK) == LEAD4_PAT) begin
               partial_in = {18'd0, in_byte[2:0]};
               owed_in    = 2'd3;
               lead_ok    = 1'b1;
            end else begin
               err        = 1'b1;
               err_status = ST_BADLEAD;
            end
            // A sequence that starts on the final byte can never finish.
            if (lead_ok && in_last) begin
               err        = 1'b1;
               err_status = ST_NOSPACE;
            end
         end else begin
            if ((in_byte & CONT_MASK) != CONT_PAT) begin
               err        = 1'b1;
               err_status = ST_BADCONT;
            end else begin
               owed_in = owed_ff - 2'd1;
               if (owed_in == 2'd0) begin
                  emit       = 1'b1;
                  emit_cp    = shifted;
                  partial_in = '0;
               end else begin
                  partial_in = shifted;
                  if (in_last) begin
                     err        = 1'b1;
                     err_status = ST_NOSPACE;
                  end
               end
            end
         end

         if (err) begin
            push.count  = 2'd1;
            push.first  = '{status: err_status, code_point: '0,
                            emitted_count: count_ff, run_end: 1'b1};
            owed_in     = '0;
            partial_in  = '0;
            count_in    = '0;
            discard_in  = !in_last;
         end else if (emit) begin
            push.first = '{status: ST_POINT, code_point: emit_cp,
                           emitted_count: cnt_inc, run_end: 1'b0};
            if (emit_cp != '0 && cnt_inc < capacity && !in_last) begin
               push.count = 2'd1;
               count_in   = cnt_inc;
            end else begin
               // Normal stop: a DONE result follows if it still fits, else a NOSPACE result.
               push.count = 2'd2;
               if (cnt_next_slot >= {1'b0, capacity}) begin
                  push.second = '{status: ST_NOSPACE, code_point: '0,
                                  emitted_count: cnt_inc, run_end: 1'b1};
               end else begin
                  push.second = '{status: ST_DONE, code_point: '0,
                                  emitted_count: cnt_next_slot[CountWidth-1:0],
                                  run_end: 1'b1};
               end
               owed_in    = '0;
               partial_in = '0;
               count_in   = '0;
               discard_in = !in_last;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff    <= '0;
         partial_ff <= '0;
         count_ff   <= '0;
         discard_ff <= 1'b0;
      end else begin
         owed_ff    <= owed_in;
         partial_ff <= partial_in;
         count_ff   <= count_in;
         discard_ff <= discard_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/u8d_result_queue.sv
// ----------------------------------------------------------------------------
// u8d_result_queue
// Small result register queue: takes up to two results per cycle and hands
// out one per transfer on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module u8d_result_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire u8d_pkg::push_type  push,
   output logic                    room,
   output logic                    out_valid,
   input  wire logic               out_stall,
   output u8d_pkg::result_type     out_result
);
   import u8d_pkg::*;

   localparam int unsigned PtrWidth = $clog2(QueueDepth);
   localparam int unsigned CntWidth = $clog2(QueueDepth + 1);

   result_type          entry_ff [QueueDepth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] fill_ff, fill_in;
   logic                pop;
   logic [PtrWidth-1:0] wr_next;

   assign out_valid  = (fill_ff != '0);
   assign out_result = entry_ff[rd_ptr_ff];
   assign pop        = out_valid && !out_stall;
   assign wr_next    = wr_ptr_ff + PtrWidth'(1);
   // Room for the worst case of two results from the next byte.
   assign room       = (fill_ff <= CntWidth'(QueueDepth - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrWidth'(push.count);
      rd_ptr_in = rd_ptr_ff + PtrWidth'(pop);
      fill_in   = fill_ff + CntWidth'(push.count) - CntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/utf8_to_utf32_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_to_utf32_decoder_unit
// Decodes a UTF-8 byte stream into UTF-32 code points, one byte per transfer,
// with end-of-message status results.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  req_      in         req_valid/stall    in_byte, in_last
//  rsp_      out        rsp_valid/stall    status, code_point, emitted_count,
//                                          run_end
//  csr_      in         csr_valid/ready    output_capacity
//
//  One byte is accepted per cycle while req_stall is low; its results are written
//  to the result queue at the same edge and can leave on the next cycle.
//  A byte that stops decoding normally gives two results; an error gives one.
//  The output side, one result per cycle while rsp_stall is low, sets the
//  sustained rate, and the four-entry result queue absorbs the extra.
//  Reset clears the sequence state, the queue and sets the capacity to 65535.
//  req_stall rises when the queue cannot take two more results.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf32_decoder_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [7:0]                        req_in_byte,
   input  wire logic                              req_in_last,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [u8d_pkg::StatusWidth-1:0]        rsp_status,
   output logic [u8d_pkg::CpWidth-1:0]            rsp_code_point,
   output logic [u8d_pkg::CountWidth-1:0]         rsp_emitted_count,
   output logic                                   rsp_run_end,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [u8d_pkg::CountWidth-1:0]    csr_output_capacity
);
   import u8d_pkg::*;

   logic [CountWidth-1:0] capacity_ff;
   logic                  room;
   logic                  req_accept;
   push_type              push;
   result_type            head;

   assign csr_ready  = 1'b1;
   assign req_stall  = !room;
   assign req_accept = req_valid && room;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_output_capacity;
      end
   end

   u8d_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_accept),
      .in_byte   (req_in_byte),
      .in_last   (req_in_last),
      .capacity  (capacity_ff),
      .push      (push)
   );

   u8d_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_result (head)
   );

   assign rsp_status        = head.status;
   assign rsp_code_point    = head.code_point;
   assign rsp_emitted_count = head.emitted_count;
   assign rsp_run_end       = head.run_end;

endmodule

`default_nettype wire

FILE: rtl/u8d_checker.sv
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks for the decoder unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module u8d_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_stall,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic [u8d_pkg::StatusWidth-1:0]   rsp_status,
   input wire logic [u8d_pkg::CpWidth-1:0]       rsp_code_point,
   input wire logic [u8d_pkg::CountWidth-1:0]    rsp_emitted_count,
   input wire logic                              rsp_run_end
);
   import u8d_pkg::*;

   // A stalled result stays offered and unchanged.
   `U8D_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_code_point) && $stable(rsp_emitted_count) && $stable(rsp_run_end), "stalled result changed")

   // Every status other than a code point closes the message.
   `U8D_ASSERT(a_status_ends, clock, reset, rsp_valid && rsp_status != ST_POINT |-> rsp_run_end, "status result without run end")

   // A code point result never closes the message by itself.
   `U8D_ASSERT(a_point_open, clock, reset, rsp_valid && rsp_status == ST_POINT |-> !rsp_run_end, "code point flagged as run end")

   // Status results carry no code point.
   `U8D_ASSERT(a_status_zero, clock, reset, rsp_valid && rsp_status != ST_POINT |-> rsp_code_point == '0, "status result with code point")

   // The queue comes out of reset empty and ready.
   `U8D_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid && !req_stall, "queue not empty after reset")

endmodule

bind utf8_to_utf32_decoder_unit u8d_checker u_checker (.*);

`default_nettype wire
